FILE: hdl/abt_pkg.sv
// ============================================================================
// abt_pkg: shared types and constants for the absorbing border taper
// Operation codes, default sizes and the Q1.15 scaling helper.
// ============================================================================
package abt_pkg;

    localparam int MAX_BORDER_DEF = 64;
    localparam int COORD_BITS_DEF = 13;

    localparam int SAMPLE_W = 32;
    localparam int COEF_W   = 16;
    localparam int PROD_W   = SAMPLE_W + COEF_W + 1;
    localparam int FRAC_W   = 15;

    typedef logic [1:0]                 op_t;
    typedef logic [COEF_W-1:0]          coef_t;
    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [PROD_W-1:0]   prod_t;

    localparam op_t OP_LOAD_X = 2'd0;
    localparam op_t OP_LOAD_Z = 2'd1;
    localparam op_t OP_TAPER  = 2'd2;
    localparam op_t OP_NOP    = 2'd3;

    // Unity gain in Q1.15.
    localparam coef_t COEF_ONE = coef_t'(1 << FRAC_W);

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_INTERIOR_WIDTH = 2'd0;
    localparam logic [1:0] REG_INTERIOR_DEPTH = 2'd1;
    localparam logic [1:0] REG_BORDER_WIDTH   = 2'd2;
    localparam logic [1:0] REG_BORDER_DEPTH   = 2'd3;

    // Drop the fraction (floor) and clamp to the signed sample range.
    function automatic sample_t scale_sat(input prod_t p);
        prod_t q;
        q = p >>> FRAC_W;
        if (q[PROD_W-1:SAMPLE_W-1] == '0 || q[PROD_W-1:SAMPLE_W-1] == '1) begin
            return q[SAMPLE_W-1:0];
        end
        return q[PROD_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
    endfunction

endpackage

FILE: hdl/absorbing_border_taper.sv
// ============================================================================
// absorbing_border_taper: border damping for a padded wavefield grid
// Scales samples in the absorbing border by per-axis Q1.15 coefficients.
// ============================================================================
// Usage:
//   Input channel (s_*): each transfer carries an op code. OP_LOAD_X and
//   OP_LOAD_Z write s_coef_value into entry s_coef_index of the x or z
//   coefficient table and produce no result. OP_TAPER takes s_sample_in at
//   grid position (s_x_pos, s_z_pos) and produces one result on m_*.
//   OP_NOP is taken and dropped.
//   Configuration (APB): interior_width at 0x0, interior_depth at 0x4,
//   border_width at 0x8, border_depth at 0xC. Write only while idle.
//   Throughput is one item per cycle while m_ready does not stall the
//   pipeline; the z and x multipliers each sit in their own stage, and
//   the coefficient memories are read in the accept cycle into a
//   stage 1 register.
//   Reset clears the pipeline valids and restores the register defaults
//   (256, 256, 32, 32). The coefficient tables are not cleared: load every
//   entry a taper will use before sending samples.
//   When the receiver stalls, the output holds and earlier stages keep
//   filling bubbles, so inputs are still taken until the pipeline is full.
// ============================================================================
module absorbing_border_taper #(
    parameter int MAX_BORDER = abt_pkg::MAX_BORDER_DEF,
    parameter int COORD_BITS = abt_pkg::COORD_BITS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    // input channel
    input  logic                    s_valid,
    output logic                    s_ready,
    input  abt_pkg::op_t            s_op,
    input  logic [5:0]              s_coef_index,
    input  abt_pkg::coef_t          s_coef_value,
    input  logic [COORD_BITS-1:0]   s_x_pos,
    input  logic [COORD_BITS-1:0]   s_z_pos,
    input  abt_pkg::sample_t        s_sample_in,
    // result channel
    output logic                    m_valid,
    input  logic                    m_ready,
    output abt_pkg::sample_t        m_sample_out,
    // configuration port
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [3:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);
    import abt_pkg::*;

    // Table index width; one bit minimum so a single-entry table still works.
    localparam int IDX_W = (MAX_BORDER > 1) ? $clog2(MAX_BORDER) : 1;
    // Wide enough for a position and for interior + 2 * border.
    localparam int CW = ((COORD_BITS > 14) ? COORD_BITS : 14) + 1;
    localparam logic [CW-1:0] MAX_BORDER_C = CW'(MAX_BORDER);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [12:0] interior_width_reg;
    logic [12:0] interior_depth_reg;
    logic [6:0]  border_width_reg;
    logic [6:0]  border_depth_reg;
    logic        cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            interior_width_reg <= 13'd256;
            interior_depth_reg <= 13'd256;
            border_width_reg   <= 7'd32;
            border_depth_reg   <= 7'd32;
        end else if (cfg_write) begin
            unique case (paddr[3:2])
                REG_INTERIOR_WIDTH: interior_width_reg <= pwdata[12:0];
                REG_INTERIOR_DEPTH: interior_depth_reg <= pwdata[12:0];
                REG_BORDER_WIDTH:   border_width_reg   <= pwdata[6:0];
                REG_BORDER_DEPTH:   border_depth_reg   <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_INTERIOR_WIDTH: prdata = {19'd0, interior_width_reg};
            REG_INTERIOR_DEPTH: prdata = {19'd0, interior_depth_reg};
            REG_BORDER_WIDTH:   prdata = {25'd0, border_width_reg};
            REG_BORDER_DEPTH:   prdata = {25'd0, border_depth_reg};
            default:            prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Border lookup: returns {hit, table index}. The far border is
    // mirrored so its outermost cell uses entry 0.
    // ------------------------------------------------------------------
    function automatic logic [IDX_W:0] border_lookup(input logic [CW-1:0] pos,
                                                     input logic [CW-1:0] interior,
                                                     input logic [CW-1:0] bord);
        logic [CW-1:0] b;
        logic [CW-1:0] hi_start;
        logic [CW-1:0] hi_end;
        logic [CW-1:0] mir;
        b        = (bord > MAX_BORDER_C) ? MAX_BORDER_C : bord;
        hi_start = interior + b;
        hi_end   = hi_start + b;
        mir      = hi_end - CW'(1) - pos;
        if (pos < b) begin
            return {1'b1, pos[IDX_W-1:0]};
        end else if (pos >= hi_start && pos < hi_end) begin
            return {1'b1, mir[IDX_W-1:0]};
        end
        return '0;
    endfunction

    logic [IDX_W:0]   z_look;
    logic [IDX_W:0]   x_look;
    logic [CW-1:0]    load_idx_ext;
    logic             load_in_range;
    logic             s_xfer;

    assign z_look = border_lookup(CW'(s_z_pos), CW'(interior_depth_reg), CW'(border_depth_reg));
    assign x_look = border_lookup(CW'(s_x_pos), CW'(interior_width_reg), CW'(border_width_reg));

    assign load_idx_ext  = CW'(s_coef_index);
    assign load_in_range = load_idx_ext < MAX_BORDER_C;
    assign s_xfer        = s_valid && s_ready;

    // ------------------------------------------------------------------
    // Pipeline enables: a stage advances when empty or when the next
    // stage advances, so bubbles collapse under backpressure.
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic en1, en2, en3, en4, en5;

    assign en5 = !v5_reg || m_ready;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    assign s_ready = en1;

    // ------------------------------------------------------------------
    // Coefficient memories: write on a load transfer, read in stage 1.
    // A load followed by a taper of the same entry is safe: the write
    // lands on the edge that accepts the load, before the taper's read.
    // ------------------------------------------------------------------
    coef_t x_mem [MAX_BORDER];
    coef_t z_mem [MAX_BORDER];
    coef_t xc1_reg;
    coef_t zc1_reg;

    always_ff @(posedge aclk) begin
        if (s_xfer && load_in_range && s_op == OP_LOAD_X) begin
            x_mem[load_idx_ext[IDX_W-1:0]] <= s_coef_value;
        end
        if (en1) begin
            xc1_reg <= x_mem[x_look[IDX_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer && load_in_range && s_op == OP_LOAD_Z) begin
            z_mem[load_idx_ext[IDX_W-1:0]] <= s_coef_value;
        end
        if (en1) begin
            zc1_reg <= z_mem[z_look[IDX_W-1:0]];
        end
    end

    // ------------------------------------------------------------------
    // Datapath stages
    //   1: coefficient read, sample and hit flags
    //   2: sample * z coefficient (unity when not in a z border)
    //   3: scale and saturate
    //   4: * x coefficient (unity when not in an x border)
    //   5: scale and saturate into the output register
    // ------------------------------------------------------------------
    sample_t s1_reg;
    logic    zhit1_reg;
    logic    xhit1_reg;
    prod_t   p2_reg;
    coef_t   xc2_reg;
    sample_t s3_reg;
    coef_t   xc3_reg;
    prod_t   p4_reg;
    sample_t out5_reg;

    coef_t   zc_eff;
    coef_t   xc_eff;
    prod_t   p2_next;
    prod_t   p4_next;

    assign zc_eff  = zhit1_reg ? zc1_reg : COEF_ONE;
    assign xc_eff  = xhit1_reg ? xc1_reg : COEF_ONE;
    assign p2_next = s1_reg * $signed({1'b0, zc_eff});
    assign p4_next = s3_reg * $signed({1'b0, xc3_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= s_valid && (s_op == OP_TAPER);
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            s1_reg    <= s_sample_in;
            zhit1_reg <= z_look[IDX_W];
            xhit1_reg <= x_look[IDX_W];
        end
        if (en2) begin
            p2_reg  <= p2_next;
            xc2_reg <= xc_eff;
        end
        if (en3) begin
            s3_reg  <= scale_sat(p2_reg);
            xc3_reg <= xc2_reg;
        end
        if (en4) begin
            p4_reg <= p4_next;
        end
        if (en5) begin
            out5_reg <= scale_sat(p4_reg);
        end
    end

    assign m_valid      = v5_reg;
    assign m_sample_out = out5_reg;

endmodule

FILE: hdl/abt_checker.sv
// ============================================================================
// abt_checker: port-level checks for absorbing_border_taper
// Tracks taper transfers in flight against delivered results.
// ============================================================================
module abt_checker (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_valid,
    input logic             s_ready,
    input abt_pkg::op_t     s_op,
    input logic             m_valid,
    input logic             m_ready,
    input abt_pkg::sample_t m_sample_out
);
    import abt_pkg::*;

    logic [2:0] cnt_reg;
    logic [2:0] cnt_next;
    logic       inc;
    logic       dec;

    assign inc      = s_valid && s_ready && (s_op == OP_TAPER);
    assign dec      = m_valid && m_ready;
    assign cnt_next = cnt_reg + {2'd0, inc} - {2'd0, dec};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    // Five pipeline stages hold at most five samples.
    a_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 3'd5)
        else $error("more taper transfers in flight than pipeline stages");

    a_no_phantom: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> cnt_reg != 3'd0)
        else $error("result shown with no taper transfer outstanding");

    a_ready_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input stalled while the receiver takes results");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_sample_out))
        else $error("stalled result changed or dropped");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind absorbing_border_taper abt_checker u_abt_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .s_op         (s_op),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_sample_out (m_sample_out)
);
